// ----- design/sss_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sss_pkg
// Types and codes shared by the sensor sampling sequencer.
// ---------------------------------------------------------------------------
package sss_pkg;

	typedef struct packed {
		logic [1:0] event_req;
		logic [1:0] uart_status;
		logic       fault_flag;
		logic       config_record_found;
	} sss_in_t;

	typedef struct packed {
		logic [4:0]  next_state;
		logic [3:0]  action;
		logic [10:0] elapsed_minutes;
		logic        sleep_request;
		logic        watchdog_kick;
	} sss_out_t;

	localparam int unsigned NUM_STATES = 18;

	typedef enum logic [NUM_STATES-1:0] {
		ST_INIT       = 18'h00001,
		ST_PWR_ON     = 18'h00002,
		ST_WAIT_PWR   = 18'h00004,
		ST_BUS_INIT   = 18'h00008,
		ST_TAG_INIT   = 18'h00010,
		ST_UART_CHK   = 18'h00020,
		ST_ERR_CHK    = 18'h00040,
		ST_RTC_START  = 18'h00080,
		ST_CNT_CHK    = 18'h00100,
		ST_CONV_START = 18'h00200,
		ST_WAIT_CONV  = 18'h00400,
		ST_READ_OFF   = 18'h00800,
		ST_WAIT_TICK  = 18'h01000,
		ST_REPWR      = 18'h02000,
		ST_WAIT_REPWR = 18'h04000,
		ST_DEEP_SLEEP = 18'h08000,
		ST_ERROR      = 18'h10000,
		ST_HALT       = 18'h20000
	} sss_state_t;

	// events
	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_RTC_TICK  = 2'd1;
	localparam logic [1:0] EV_TIMER     = 2'd2;
	localparam logic [1:0] EV_CONV_DONE = 2'd3;

	// serial link status
	localparam logic [1:0] UART_RUNNING = 2'd0;
	localparam logic [1:0] UART_WAITING = 2'd1;

	// actions
	localparam logic [3:0] ACT_NONE       = 4'd0;
	localparam logic [3:0] ACT_INIT       = 4'd1;
	localparam logic [3:0] ACT_POWER_ON   = 4'd2;
	localparam logic [3:0] ACT_BUS_INIT   = 4'd3;
	localparam logic [3:0] ACT_TAG_INIT   = 4'd4;
	localparam logic [3:0] ACT_READ_REC   = 4'd5;
	localparam logic [3:0] ACT_ERR_CHECK  = 4'd6;
	localparam logic [3:0] ACT_RTC_START  = 4'd7;
	localparam logic [3:0] ACT_CONV_START = 4'd8;
	localparam logic [3:0] ACT_READ_OFF   = 4'd9;
	localparam logic [3:0] ACT_ELAPSED    = 4'd10;
	localparam logic [3:0] ACT_RESET      = 4'd11;
	localparam logic [3:0] ACT_DEEP_SLEEP = 4'd12;

	localparam logic [10:0] INTERVAL_RESET = 11'd10;

	// numeric state code of a one-hot state
	function automatic logic [4:0] state_code(input sss_state_t s);
		logic [4:0] code;
		code = 5'd0;
		for (int i = 0; i < NUM_STATES; i++) begin
			if (s[i]) code = code | 5'(i);
		end
		return code;
	endfunction

endpackage
`default_nettype wire

// ----- design/sensor_sampling_sequencer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sensor_sampling_sequencer
// Start-up and minute-sampling control sequence of a battery sensor node.
// ---------------------------------------------------------------------------
// One input word is one pass of the control loop and yields one result word.
// The word is captured in an input register, the 18-state one-hot sequencer
// and the minute counter are evaluated against it combinationally, and the
// result lands in an output register: one word per cycle while the output is
// taken. The only stall is a full output register that the consumer does not
// take. The user writes sample_interval_minutes (reset 10) through cfg_wr_en
// and cfg_wr_data only while no word is in flight; the block does not check.
module sensor_sampling_sequencer
	import sss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire sss_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sss_out_t         out_data
);

	logic        valid_s1;
	sss_in_t     data_s1;
	logic        valid_s2;
	sss_out_t    data_s2;
	logic [10:0] interval_q;
	sss_state_t  state_q;
	logic [10:0] count_q;

	logic        adv_s1;
	sss_state_t  nxt_state;
	logic [10:0] nxt_count;
	sss_out_t    res;
	logic [11:0] cnt_inc;

	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign cnt_inc  = {1'b0, count_q} + 12'd1;

	always_comb begin
		nxt_state           = ST_HALT;
		nxt_count           = count_q;
		res.action          = ACT_NONE;
		res.elapsed_minutes = 11'd0;
		res.sleep_request   = 1'b0;
		res.watchdog_kick   = 1'b0;
		case (state_q)
			ST_INIT: begin
				res.action        = ACT_INIT;
				res.watchdog_kick = 1'b1;
				nxt_state         = ST_PWR_ON;
			end
			ST_PWR_ON: begin
				res.action = ACT_POWER_ON;
				nxt_state  = ST_WAIT_PWR;
			end
			ST_WAIT_PWR: begin
				if (data_s1.event_req == EV_TIMER) begin
					res.action = ACT_BUS_INIT;
					nxt_state  = ST_BUS_INIT;
				end else begin
					res.sleep_request = 1'b1;
					nxt_state         = ST_WAIT_PWR;
				end
			end
			ST_BUS_INIT: begin
				res.action = ACT_TAG_INIT;
				nxt_state  = ST_TAG_INIT;
			end
			ST_TAG_INIT: begin
				res.action = ACT_READ_REC;
				nxt_state  = ST_UART_CHK;
			end
			ST_UART_CHK: begin
				res.watchdog_kick = 1'b1;
				if (data_s1.uart_status == UART_RUNNING) begin
					nxt_state = ST_UART_CHK;
				end else if (data_s1.uart_status == UART_WAITING) begin
					res.sleep_request = 1'b1;
					nxt_state         = ST_UART_CHK;
				end else begin
					// finished, and the unused code three, move on
					nxt_state = ST_ERR_CHK;
				end
			end
			ST_ERR_CHK: begin
				res.action        = ACT_ERR_CHECK;
				res.watchdog_kick = 1'b1;
				nxt_state         = data_s1.fault_flag ? ST_DEEP_SLEEP : ST_RTC_START;
			end
			ST_RTC_START: begin
				res.action = ACT_RTC_START;
				nxt_state  = ST_CNT_CHK;
			end
			ST_CNT_CHK: begin
				nxt_count = (cnt_inc < {1'b0, interval_q}) ? cnt_inc[10:0] : 11'd0;
				if (count_q == 11'd0) begin
					nxt_state = ST_CONV_START;
				end else if (data_s1.config_record_found) begin
					// software reset clears sequence and counter
					res.action = ACT_RESET;
					nxt_count  = 11'd0;
					nxt_state  = ST_INIT;
				end else begin
					res.action          = ACT_ELAPSED;
					res.elapsed_minutes = count_q;
					nxt_state           = ST_WAIT_TICK;
				end
			end
			ST_CONV_START: begin
				res.action = ACT_CONV_START;
				nxt_state  = ST_WAIT_CONV;
			end
			ST_WAIT_CONV: begin
				if (data_s1.event_req == EV_CONV_DONE) begin
					nxt_state = ST_READ_OFF;
				end else begin
					res.sleep_request = 1'b1;
					nxt_state         = ST_WAIT_CONV;
				end
			end
			ST_READ_OFF: begin
				res.action = ACT_READ_OFF;
				nxt_state  = ST_WAIT_TICK;
			end
			ST_WAIT_TICK: begin
				res.watchdog_kick = 1'b1;
				if (data_s1.event_req == EV_RTC_TICK) begin
					nxt_state = ST_REPWR;
				end else begin
					res.sleep_request = 1'b1;
					nxt_state         = ST_WAIT_TICK;
				end
			end
			ST_REPWR: begin
				res.action = ACT_POWER_ON;
				nxt_state  = ST_WAIT_REPWR;
			end
			ST_WAIT_REPWR: begin
				if (data_s1.event_req == EV_TIMER) begin
					res.action = ACT_BUS_INIT;
					nxt_state  = ST_CNT_CHK;
				end else begin
					res.sleep_request = 1'b1;
					nxt_state         = ST_WAIT_REPWR;
				end
			end
			ST_DEEP_SLEEP: begin
				res.action = ACT_DEEP_SLEEP;
				nxt_state  = ST_DEEP_SLEEP;
			end
			ST_ERROR: begin
				// no way out of the error state: halt
				res.sleep_request = 1'b1;
				nxt_state         = ST_HALT;
			end
			default: begin
				nxt_state = ST_HALT;
			end
		endcase
		res.next_state = state_code(nxt_state);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			interval_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= ST_INIT;
			count_q  <= 11'd0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s1) valid_s2 <= valid_s1;
			if (valid_s1 && adv_s1) begin
				state_q <= nxt_state;
				count_q <= nxt_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_s1 <= in_data;
		if (adv_s1 && valid_s1) data_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// once halted the sequence never leaves
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HALT |=> state_q == ST_HALT)
		else $error("sequencer left the halted state");

	// a nonzero elapsed count only comes with the elapsed action
	a_elapsed_action: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.elapsed_minutes != 11'd0 |-> data_s2.action == ACT_ELAPSED)
		else $error("elapsed minutes without elapsed action");

	// input stalls only when both stages hold a word and the output is stuck
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled with room in the pipeline");

	// a stalled input word leaves the sequence state alone
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> $stable(state_q) && $stable(count_q))
		else $error("sequence state moved during a stall");

endmodule
`default_nettype wire

// ----- dv/sss_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sss_checker
// Watches both channels of the sensor sampling sequencer, predicts every
// result word and compares it field by field.
// ---------------------------------------------------------------------------
// Each accepted input word is run through a cycle-free model of the
// sequence (state code, minute counter, interval register) and the expected
// result is queued. Each accepted output word is checked against the oldest
// entry. Mismatches and unexpected words are counted in fail_count.
module sss_checker
	import sss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire sss_in_t     in_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire sss_out_t    out_data,
	output int               fail_count,
	output int               in_flight,
	output int               results_seen,
	output logic             at_uart_chk,
	output logic             at_err_chk,
	output logic             in_deep_sleep
);

	typedef enum logic [4:0] {
		C_INIT, C_PWR_ON, C_WAIT_PWR, C_BUS_INIT, C_TAG_INIT, C_UART_CHK,
		C_ERR_CHK, C_RTC_START, C_CNT_CHK, C_CONV_START, C_WAIT_CONV,
		C_READ_OFF, C_WAIT_TICK, C_REPWR, C_WAIT_REPWR, C_DEEP_SLEEP,
		C_ERROR, C_HALT
	} seq_code_t;

	seq_code_t   ctl_state;
	logic [10:0] minutes;
	logic [10:0] interval;
	sss_out_t    expected_q[$];

	assign at_uart_chk   = (ctl_state == C_UART_CHK);
	assign at_err_chk    = (ctl_state == C_ERR_CHK);
	assign in_deep_sleep = (ctl_state == C_DEEP_SLEEP);

	// One pass of the control loop: result word plus the next state/counter.
	function automatic sss_out_t predict_pass(input sss_in_t w, input seq_code_t st,
			input logic [10:0] mins, input logic [10:0] ivl,
			output seq_code_t nst, output logic [10:0] nmins);
		sss_out_t r;
		r = '0;
		nst = C_HALT;
		nmins = mins;
		case (st)
			C_INIT: begin
				r.action = ACT_INIT;
				r.watchdog_kick = 1'b1;
				nst = C_PWR_ON;
			end
			C_PWR_ON: begin
				r.action = ACT_POWER_ON;
				nst = C_WAIT_PWR;
			end
			C_WAIT_PWR: begin
				if (w.event_req == EV_TIMER) begin
					r.action = ACT_BUS_INIT;
					nst = C_BUS_INIT;
				end else begin
					r.sleep_request = 1'b1;
					nst = C_WAIT_PWR;
				end
			end
			C_BUS_INIT: begin
				r.action = ACT_TAG_INIT;
				nst = C_TAG_INIT;
			end
			C_TAG_INIT: begin
				r.action = ACT_READ_REC;
				nst = C_UART_CHK;
			end
			C_UART_CHK: begin
				r.watchdog_kick = 1'b1;
				if (w.uart_status == UART_RUNNING) begin
					nst = C_UART_CHK;
				end else if (w.uart_status == UART_WAITING) begin
					r.sleep_request = 1'b1;
					nst = C_UART_CHK;
				end else begin
					nst = C_ERR_CHK; // finished, and the unused code 3 as well
				end
			end
			C_ERR_CHK: begin
				r.action = ACT_ERR_CHECK;
				r.watchdog_kick = 1'b1;
				nst = w.fault_flag ? C_DEEP_SLEEP : C_RTC_START;
			end
			C_RTC_START: begin
				r.action = ACT_RTC_START;
				nst = C_CNT_CHK;
			end
			C_CNT_CHK: begin
				// 12-bit compare so a wide interval cannot wrap the sum
				if (({1'b0, mins} + 12'd1) < {1'b0, ivl}) nmins = mins + 11'd1;
				else nmins = '0;
				if (mins == '0) begin
					nst = C_CONV_START;
				end else if (w.config_record_found) begin
					r.action = ACT_RESET;
					nmins = '0;
					nst = C_INIT;
				end else begin
					r.action = ACT_ELAPSED;
					r.elapsed_minutes = mins;
					nst = C_WAIT_TICK;
				end
			end
			C_CONV_START: begin
				r.action = ACT_CONV_START;
				nst = C_WAIT_CONV;
			end
			C_WAIT_CONV: begin
				if (w.event_req == EV_CONV_DONE) begin
					nst = C_READ_OFF;
				end else begin
					r.sleep_request = 1'b1;
					nst = C_WAIT_CONV;
				end
			end
			C_READ_OFF: begin
				r.action = ACT_READ_OFF;
				nst = C_WAIT_TICK;
			end
			C_WAIT_TICK: begin
				r.watchdog_kick = 1'b1;
				if (w.event_req == EV_RTC_TICK) begin
					nst = C_REPWR;
				end else begin
					r.sleep_request = 1'b1;
					nst = C_WAIT_TICK;
				end
			end
			C_REPWR: begin
				r.action = ACT_POWER_ON;
				nst = C_WAIT_REPWR;
			end
			C_WAIT_REPWR: begin
				if (w.event_req == EV_TIMER) begin
					r.action = ACT_BUS_INIT;
					nst = C_CNT_CHK;
				end else begin
					r.sleep_request = 1'b1;
					nst = C_WAIT_REPWR;
				end
			end
			C_DEEP_SLEEP: begin
				r.action = ACT_DEEP_SLEEP;
				nst = C_DEEP_SLEEP;
			end
			C_ERROR: begin
				r.sleep_request = 1'b1;
				nst = C_HALT;
			end
			default: begin
				nst = C_HALT;
			end
		endcase
		r.next_state = nst;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch on result %0d: %0s", $realtime, results_seen, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sss_out_t    want;
		sss_out_t    got;
		seq_code_t   nst;
		logic [10:0] nmins;
		if (!arst_n) begin
			ctl_state <= C_INIT;
			minutes <= '0;
			interval <= INTERVAL_RESET;
			in_flight <= 0;
			results_seen <= 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_wr_en) interval <= cfg_wr_data;
			if (out_valid && out_ready) begin
				got = out_data;
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("word with nothing expected (state %0d)",
						got.next_state));
				end else begin
					want = expected_q.pop_front();
					if (got.next_state !== want.next_state)
						report_mismatch($sformatf("next_state %0d, want %0d",
							got.next_state, want.next_state));
					if (got.action !== want.action)
						report_mismatch($sformatf("action %0d, want %0d",
							got.action, want.action));
					if (got.elapsed_minutes !== want.elapsed_minutes)
						report_mismatch($sformatf("elapsed_minutes %0d, want %0d",
							got.elapsed_minutes, want.elapsed_minutes));
					if (got.sleep_request !== want.sleep_request)
						report_mismatch($sformatf("sleep_request %0b, want %0b",
							got.sleep_request, want.sleep_request));
					if (got.watchdog_kick !== want.watchdog_kick)
						report_mismatch($sformatf("watchdog_kick %0b, want %0b",
							got.watchdog_kick, want.watchdog_kick));
				end
			end
			if (in_valid && in_ready) begin
				want = predict_pass(in_data, ctl_state, minutes, interval, nst, nmins);
				expected_q.push_back(want);
				ctl_state <= nst;
				minutes <= nmins;
			end
			in_flight <= expected_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_sensor_sampling_sequencer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb_sensor_sampling_sequencer
// Self-checking bench for the sensor sampling sequencer.
// ---------------------------------------------------------------------------
// A directed walk covers the start-up path, every wait state, the serial
// check variants, both counter branches and the software reset. Random
// phases then run the sampling loop under several interval settings (0, 1,
// 2, 3, 1440, 2047 and a random one) with random idling on both sides, one
// long consumer hold-off and one phase with no idling. The last phase drives
// the sequence into deep sleep. Checking lives in sss_checker.
module tb_sensor_sampling_sequencer;
	import sss_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int WORDS_PER_PHASE = 220;
	localparam int NUM_PHASES      = 7;
	localparam int CALM_PHASE      = 2;
	localparam int HOLD_AT         = 600;
	localparam int HOLD_CYCLES     = 90;
	localparam int IDLE_PCT        = 14;

	localparam logic [1:0] UART_DONE = 2'd2;
	localparam logic [1:0] UART_ODD  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	sss_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	sss_out_t    out_data;

	int   fail_count;
	int   in_flight;
	int   results_seen;
	logic at_uart_chk;
	logic at_err_chk;
	logic in_deep_sleep;

	logic    calm = 1'b0;
	int      hold_left = 0;
	logic    held = 1'b0;
	int      cycles = 0;
	int      words_sent = 0;
	bit      fresh = 1'b0;  // a word was accepted at the current edge
	sss_in_t last_word = '0;

	sensor_sampling_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	sss_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.in_flight(in_flight),
		.results_seen(results_seen),
		.at_uart_chk(at_uart_chk),
		.at_err_chk(at_err_chk),
		.in_deep_sleep(in_deep_sleep)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, in_flight);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Consumer: random stalls, one long hold-off once traffic is flowing.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!held && results_seen >= HOLD_AT) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic sss_in_t word(input logic [1:0] evt, input logic [1:0] uart,
			input logic fault, input logic rec);
		sss_in_t w;
		w.event_req = evt;
		w.uart_status = uart;
		w.fault_flag = fault;
		w.config_record_found = rec;
		return w;
	endfunction

	// Fault stays low whenever the next word lands in the error check, since
	// deep sleep is permanent; doom forces the way there.
	function automatic sss_in_t rand_word(input bit doom);
		sss_in_t w;
		bit      err_ahead;
		err_ahead = fresh ? (at_uart_chk && last_word.uart_status >= UART_DONE) : at_err_chk;
		w.event_req = 2'($urandom_range(0, 3));
		w.uart_status = 2'($urandom_range(0, 3));
		w.fault_flag = doom || (!err_ahead && $urandom_range(0, 1) == 1);
		w.config_record_found = doom || ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	task automatic idle_gap();
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
			fresh = 1'b0;
		end
	endtask

	task automatic push_word(input sss_in_t w);
		in_valid <= 1'b1;
		in_data <= w;
		last_word = w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fresh = 1'b1;
		words_sent++;
	endtask

	task automatic send_directed(input sss_in_t w);
		idle_gap();
		push_word(w);
	endtask

	task automatic send_random(input bit doom);
		idle_gap();
		push_word(rand_word(doom));
	endtask

	// sender pause until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		fresh = 1'b0;
	endtask

	task automatic write_interval(input logic [10:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [10:0] ivl_list[NUM_PHASES];
		int          sleepers;
		ivl_list = '{11'd1, 11'd0, 11'd2, 11'd1440, 11'd2047, 11'd3, 11'd0};
		ivl_list[NUM_PHASES-1] = 11'($urandom_range(4, 60));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk with the reset interval of 10
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_CONV_DONE, UART_ODD, 1'b1, 1'b1));
		send_directed(word(EV_RTC_TICK, UART_WAITING, 1'b0, 1'b0)); // no timer yet
		send_directed(word(EV_TIMER, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));   // serial running
		send_directed(word(EV_NONE, UART_WAITING, 1'b0, 1'b0));   // serial waiting
		send_directed(word(EV_NONE, UART_ODD, 1'b0, 1'b0));       // code 3 = finished
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b1));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b1));   // count zero wins
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_CONV_DONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_CONV_DONE, UART_RUNNING, 1'b0, 1'b0)); // not a tick
		send_directed(word(EV_RTC_TICK, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_TIMER, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));   // elapsed 1
		send_directed(word(EV_RTC_TICK, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b0));
		send_directed(word(EV_TIMER, UART_DONE, 1'b0, 1'b0));
		send_directed(word(EV_NONE, UART_RUNNING, 1'b0, 1'b1));   // software reset
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_interval(ivl_list[p]);
			calm <= (p == CALM_PHASE);
			for (int k = 0; k < WORDS_PER_PHASE; k++) send_random(1'b0);
			drain();
		end

		// final phase: software reset back to start-up, fault into deep sleep
		calm <= 1'b0;
		write_interval(11'd5);
		sleepers = 0;
		while (sleepers < 6) begin
			send_random(1'b1);
			if (in_deep_sleep) sleepers++;
		end
		drain();
		repeat (8) @(posedge clk);

		$display("%0d words sent under %0d interval settings, %0d results checked",
			words_sent, NUM_PHASES + 2, results_seen);
		$display("consumer hold-off seen: %0b, deep sleep reached: %0b", held, in_deep_sleep);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
design/sss_pkg.sv
design/sensor_sampling_sequencer.sv
dv/sss_checker.sv
dv/tb_sensor_sampling_sequencer.sv
